>>> src/fdssf_pkg.sv
// Shared types, constants and the hex segment table of the four-digit
// seven-segment formatter. No dependencies.
`timescale 1ns / 1ps

package fdssf_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int DIGIT_W     = 4;
    localparam int SEG_W       = 8;
    localparam int NUM_W       = 16;
    localparam int RADIX_W     = 5;
    // bits of the dividend handled by one divider stage
    localparam int STEP_BITS   = 8;
    localparam int STAGES_PER_DIGIT = NUM_W / STEP_BITS;
    localparam int DIV_STAGES  = NUM_DIGITS * STAGES_PER_DIGIT;

    localparam logic [SEG_W-1:0]   SEG_POINT  = 8'h80;
    localparam logic [NUM_W-1:0]   REAL_MAX   = 16'd9999;
    localparam logic [RADIX_W-1:0] RADIX_REAL = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;

    typedef enum logic [1:0] {
        CMD_RAW    = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_INT    = 2'd2,
        CMD_REAL   = 2'd3
    } t_cmd;

    // one item in flight through the divider chain
    typedef struct packed {
        t_cmd                                  cmd;
        logic [NUM_DIGITS-1:0][SEG_W-1:0]      raw;
        logic [RADIX_W-1:0]                    rad;
        logic [NUM_W-1:0]                      work;
        logic [DIGIT_W-1:0]                    rem;
        logic                                  half;
        logic [NUM_DIGITS*DIGIT_W-1:0]         digits;
    } t_pipe;

    function automatic logic [SEG_W-1:0] hex_seg(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'h0:    s = 8'b00111111;
            4'h1:    s = 8'b00000110;
            4'h2:    s = 8'b01011011;
            4'h3:    s = 8'b01001111;
            4'h4:    s = 8'b01100110;
            4'h5:    s = 8'b01101101;
            4'h6:    s = 8'b01111101;
            4'h7:    s = 8'b00000111;
            4'h8:    s = 8'b01111111;
            4'h9:    s = 8'b01101111;
            4'hA:    s = 8'b01110111;
            4'hB:    s = 8'b01111100;
            4'hC:    s = 8'b00111001;
            4'hD:    s = 8'b01011110;
            4'hE:    s = 8'b01111001;
            4'hF:    s = 8'b01110001;
            default: s = 8'b00111111;
        endcase
        return s;
    endfunction

endpackage

>>> src/fdssf_if.sv
// Request and result channel interfaces of the seven-segment formatter.
// Depends on nothing.
`timescale 1ns / 1ps

interface fdssf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  digit_a;
    logic [7:0]  digit_b;
    logic [7:0]  digit_c;
    logic [7:0]  digit_d;
    logic [15:0] number;
    logic [4:0]  radix;

    modport source (
        output valid, cmd, digit_a, digit_b, digit_c, digit_d, number, radix,
        input  ready
    );
    modport sink (
        input  valid, cmd, digit_a, digit_b, digit_c, digit_d, number, radix,
        output ready
    );
endinterface

interface fdssf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] seg_left;
    logic [7:0] seg_second;
    logic [7:0] seg_third;
    logic [7:0] seg_right;

    modport source (
        output valid, seg_left, seg_second, seg_third, seg_right,
        input  ready
    );
    modport sink (
        input  valid, seg_left, seg_second, seg_third, seg_right,
        output ready
    );
endinterface

>>> src/fdssf_div_stage.sv
// One registered stage of the digit divider chain: eight restoring
// division steps by the radix. Depends on fdssf_pkg.
`timescale 1ns / 1ps

module fdssf_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  fdssf_pkg::t_pipe i_stage,
    output logic           o_vld,
    output fdssf_pkg::t_pipe o_stage
);
    import fdssf_pkg::*;

    logic [DIGIT_W:0]     w_rem [0:STEP_BITS];
    logic [STEP_BITS-1:0] w_quo;
    logic [DIGIT_W:0]     w_shift [0:STEP_BITS-1];
    t_pipe                n_stage;
    logic                 r_vld;
    t_pipe                r_stage;

    assign w_rem[0] = {1'b0, i_stage.rem};

    // top byte of the window is divided; partial remainder stays below radix
    genvar g;
    generate
        for (g = 0; g < STEP_BITS; g++) begin : g_step
            assign w_shift[g] = {w_rem[g][DIGIT_W-1:0], i_stage.work[NUM_W-1-g]};
            assign w_quo[STEP_BITS-1-g] = (w_shift[g] >= i_stage.rad);
            assign w_rem[g+1] = w_quo[STEP_BITS-1-g] ? (w_shift[g] - i_stage.rad)
                                                     : w_shift[g];
        end
    endgenerate

    always_comb begin
        n_stage      = i_stage;
        n_stage.work = {i_stage.work[NUM_W-STEP_BITS-1:0], w_quo};
        n_stage.half = ~i_stage.half;
        if (i_stage.half) begin
            // second half done: remainder is the next digit, right to left
            n_stage.digits = {w_rem[STEP_BITS][DIGIT_W-1:0],
                              i_stage.digits[NUM_DIGITS*DIGIT_W-1:DIGIT_W]};
            n_stage.rem    = '0;
        end else begin
            n_stage.rem    = w_rem[STEP_BITS][DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> src/fdssf_lane.sv
// One display lane: passes the raw byte, or maps the encoded or divided
// digit to segments; real mode adds i_point. Depends on fdssf_pkg.
`timescale 1ns / 1ps

module fdssf_lane (
    input  fdssf_pkg::t_cmd              i_cmd,
    input  logic [fdssf_pkg::SEG_W-1:0]  i_raw,
    input  logic [fdssf_pkg::DIGIT_W-1:0] i_digit,
    input  logic                         i_point,
    output logic [fdssf_pkg::SEG_W-1:0]  o_seg
);
    import fdssf_pkg::*;

    always_comb begin
        case (i_cmd)
            CMD_RAW:    o_seg = i_raw;
            CMD_ENCODE: o_seg = hex_seg(i_raw[DIGIT_W-1:0]);
            CMD_INT:    o_seg = hex_seg(i_digit);
            CMD_REAL:   o_seg = hex_seg(i_digit) | (i_point ? SEG_POINT : '0);
            default:    o_seg = i_raw;
        endcase
    end

endmodule

>>> src/four_digit_seven_segment_formatter.sv
// Four-digit seven-segment formatter. From request to result: one prepare
// stage, eight divider stages (two per digit), one output register.
// Throughput one request per cycle; the whole pipe stalls only while the
// output register holds a result that is not taken.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
`timescale 1ns / 1ps

module four_digit_seven_segment_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdssf_in_if.sink    i_in,
    fdssf_out_if.source o_out
);
    import fdssf_pkg::*;

    logic                             w_en;
    t_cmd                             w_cmd;
    t_pipe                            n_prep;
    t_pipe                            r_prep;
    logic                             r_prep_vld;
    t_pipe                            w_stage [0:DIV_STAGES];
    logic [DIV_STAGES:0]              w_vld;
    logic [NUM_DIGITS-1:0][SEG_W-1:0] w_seg;
    logic [NUM_DIGITS-1:0][SEG_W-1:0] r_seg;
    logic                             r_out_vld;

    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;
    assign w_cmd      = t_cmd'(i_in.cmd);

    // real mode is base ten on the saturated value
    always_comb begin
        n_prep        = '0;
        n_prep.cmd    = w_cmd;
        n_prep.raw[0] = i_in.digit_a;
        n_prep.raw[1] = i_in.digit_b;
        n_prep.raw[2] = i_in.digit_c;
        n_prep.raw[3] = i_in.digit_d;
        if (w_cmd == CMD_REAL) begin
            n_prep.rad  = RADIX_REAL;
            n_prep.work = (i_in.number > REAL_MAX) ? REAL_MAX : i_in.number;
        end else begin
            n_prep.work = i_in.number;
            if (i_in.radix < RADIX_MIN) begin
                n_prep.rad = RADIX_MIN;
            end else if (i_in.radix > RADIX_MAX) begin
                n_prep.rad = RADIX_MAX;
            end else begin
                n_prep.rad = i_in.radix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_vld <= 1'b0;
        end else if (w_en) begin
            r_prep_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep <= n_prep;
        end
    end

    assign w_stage[0] = r_prep;
    assign w_vld[0]   = r_prep_vld;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_div
            fdssf_div_stage u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_vld   (w_vld[s]),
                .i_stage (w_stage[s]),
                .o_vld   (w_vld[s+1]),
                .o_stage (w_stage[s+1])
            );
        end
    endgenerate

    // digits field holds the leftmost digit in its top nibble
    genvar k;
    generate
        for (k = 0; k < NUM_DIGITS; k++) begin : g_lane
            fdssf_lane u_lane (
                .i_cmd   (w_stage[DIV_STAGES].cmd),
                .i_raw   (w_stage[DIV_STAGES].raw[k]),
                .i_digit (w_stage[DIV_STAGES].digits[(NUM_DIGITS-1-k)*DIGIT_W +: DIGIT_W]),
                .i_point (k == 1),
                .o_seg   (w_seg[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_seg <= w_seg;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.seg_left   = r_seg[0];
    assign o_out.seg_second = r_seg[1];
    assign o_out.seg_third  = r_seg[2];
    assign o_out.seg_right  = r_seg[3];

endmodule

>>> verif/fdssf_display_check.sv
// Checker for the four-digit seven-segment formatter: watches the request and
// result channels, predicts each display and compares it field by field.
// Depends on fdssf_pkg and the channel interfaces in fdssf_if.sv.
`timescale 1ns / 1ps

module fdssf_display_check (
    input  logic i_clk,
    input  logic i_rst_n,
    fdssf_in_if  i_req,
    fdssf_out_if i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import fdssf_pkg::*;

    typedef struct packed {
        logic [SEG_W-1:0] left;
        logic [SEG_W-1:0] second;
        logic [SEG_W-1:0] third;
        logic [SEG_W-1:0] right;
    } t_display;

    // gfedcba glyphs for 0..F
    localparam logic [SEG_W-1:0] HEX_GLYPHS [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    t_display pending_displays [$];
    int       fail_count = 0;

    function automatic t_display format_display(
        input t_cmd        cmd,
        input logic [7:0]  a,
        input logic [7:0]  b,
        input logic [7:0]  c,
        input logic [7:0]  d,
        input logic [15:0] num,
        input logic [4:0]  rad
    );
        logic [7:0]  segs [4];
        logic [15:0] rest;
        logic [15:0] base;
        t_display    disp;
        case (cmd)
            CMD_RAW: begin
                segs[0] = a;
                segs[1] = b;
                segs[2] = c;
                segs[3] = d;
            end
            CMD_ENCODE: begin
                segs[0] = HEX_GLYPHS[a[3:0]];
                segs[1] = HEX_GLYPHS[b[3:0]];
                segs[2] = HEX_GLYPHS[c[3:0]];
                segs[3] = HEX_GLYPHS[d[3:0]];
            end
            CMD_INT: begin
                base = (rad < RADIX_MIN) ? 16'(RADIX_MIN)
                     : (rad > RADIX_MAX) ? 16'(RADIX_MAX) : 16'(rad);
                rest = num;
                // rightmost digit first; whatever is left past four digits is dropped
                for (int k = 3; k >= 0; k--) begin
                    segs[k] = HEX_GLYPHS[4'(rest % base)];
                    rest    = rest / base;
                end
            end
            default: begin
                rest    = (num > REAL_MAX) ? REAL_MAX : num;
                segs[0] = HEX_GLYPHS[4'((rest / 1000) % 10)];
                segs[1] = HEX_GLYPHS[4'((rest / 100) % 10)] | SEG_POINT;
                segs[2] = HEX_GLYPHS[4'((rest / 10) % 10)];
                segs[3] = HEX_GLYPHS[4'(rest % 10)];
            end
        endcase
        disp.left   = segs[0];
        disp.second = segs[1];
        disp.third  = segs[2];
        disp.right  = segs[3];
        return disp;
    endfunction

    always @(posedge i_clk) begin
        t_display want;
        t_display got;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                pending_displays.push_back(format_display(t_cmd'(i_req.cmd),
                    i_req.digit_a, i_req.digit_b, i_req.digit_c, i_req.digit_d,
                    i_req.number, i_req.radix));
            end
            if (i_res.valid && i_res.ready) begin
                got.left   = i_res.seg_left;
                got.second = i_res.seg_second;
                got.third  = i_res.seg_third;
                got.right  = i_res.seg_right;
                if (pending_displays.size() == 0) begin
                    $error("result %h with no request pending", got);
                    fail_count++;
                end else begin
                    want = pending_displays.pop_front();
                    if (got.left !== want.left) begin
                        $error("seg_left expected %02h actual %02h", want.left, got.left);
                        fail_count++;
                    end
                    if (got.second !== want.second) begin
                        $error("seg_second expected %02h actual %02h",
                               want.second, got.second);
                        fail_count++;
                    end
                    if (got.third !== want.third) begin
                        $error("seg_third expected %02h actual %02h", want.third, got.third);
                        fail_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("seg_right expected %02h actual %02h", want.right, got.right);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = pending_displays.size();
    end

endmodule

>>> verif/tb.sv
// Testbench top of the four-digit seven-segment formatter: clock, reset,
// request stimulus with idle and stall phases, and the final verdict.
// Depends on fdssf_pkg, fdssf_if.sv, the formatter and fdssf_display_check.
`timescale 1ns / 1ps

module tb;
    import fdssf_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   cycle_count    = 0;

    fdssf_in_if  req_ch ();
    fdssf_out_if res_ch ();

    four_digit_seven_segment_formatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    fdssf_display_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(
        input t_cmd        cmd,
        input logic [7:0]  a,
        input logic [7:0]  b,
        input logic [7:0]  c,
        input logic [7:0]  d,
        input logic [15:0] num,
        input logic [4:0]  rad
    );
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= cmd;
        req_ch.digit_a <= a;
        req_ch.digit_b <= b;
        req_ch.digit_c <= c;
        req_ch.digit_d <= d;
        req_ch.number  <= num;
        req_ch.radix   <= rad;
        taken = 1'b0;
        while (!taken) begin
            // ready is stable mid-cycle, so sample it there
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_request();
        t_cmd        cmd;
        logic [15:0] num;
        logic [4:0]  rad;
        logic [7:0]  dg [4];
        cmd = t_cmd'($urandom_range(3));
        num = 16'($urandom);
        rad = 5'($urandom);
        for (int k = 0; k < 4; k++)
            dg[k] = 8'($urandom);
        case (cmd)
            CMD_ENCODE: begin
                if ($urandom_range(1) == 0)
                    for (int k = 0; k < 4; k++)
                        dg[k] = 8'($urandom_range(15));
            end
            CMD_INT: begin
                if ($urandom_range(4) != 0)
                    rad = 5'($urandom_range(16, 2));
                if ($urandom_range(3) == 0)
                    num = 16'($urandom_range(255));
            end
            CMD_REAL: begin
                if ($urandom_range(3) != 0)
                    num = 16'($urandom_range(9999));
            end
            default: ;
        endcase
        send_request(cmd, dg[0], dg[1], dg[2], dg[3], num, rad);
    endtask

    initial begin
        req_ch.valid   <= 1'b0;
        req_ch.cmd     <= CMD_RAW;
        req_ch.digit_a <= '0;
        req_ch.digit_b <= '0;
        req_ch.digit_c <= '0;
        req_ch.digit_d <= '0;
        req_ch.number  <= '0;
        req_ch.radix   <= '0;
        i_rst_n        <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // raw bytes, including all-off, all-on and lone point
        send_request(CMD_RAW, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 5'd0);
        send_request(CMD_RAW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 5'd31);
        send_request(CMD_RAW, 8'h80, 8'h7F, 8'h01, 8'hFE, 16'h5A5A, 5'd10);
        // every hex glyph, then digits above fifteen
        send_request(CMD_ENCODE, 8'h0, 8'h1, 8'h2, 8'h3, 16'hFFFF, 5'd31);
        send_request(CMD_ENCODE, 8'h4, 8'h5, 8'h6, 8'h7, 16'h0000, 5'd0);
        send_request(CMD_ENCODE, 8'h8, 8'h9, 8'hA, 8'hB, 16'h1234, 5'd5);
        send_request(CMD_ENCODE, 8'hC, 8'hD, 8'hE, 8'hF, 16'h8000, 5'd16);
        send_request(CMD_ENCODE, 8'h10, 8'hFF, 8'h8A, 8'hF3, 16'h0001, 5'd1);
        // integer: radix bounds, clamping, dropped high digits
        send_request(CMD_INT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 5'd10);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 5'd16);
        send_request(CMD_INT, 8'h12, 8'h34, 8'h56, 8'h78, 16'hFFFF, 5'd2);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'd5, 5'd0);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'd9, 5'd1);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'hABCD, 5'd17);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'h1234, 5'd31);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'd12345, 5'd10);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'd2400, 5'd7);
        send_request(CMD_INT, 8'h00, 8'h00, 8'h00, 8'h00, 16'd80, 5'd3);
        // real: zero, top of range, saturation, unused fields set
        send_request(CMD_REAL, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 5'd0);
        send_request(CMD_REAL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd9999, 5'd31);
        send_request(CMD_REAL, 8'h00, 8'h00, 8'h00, 8'h00, 16'd10000, 5'd2);
        send_request(CMD_REAL, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF, 5'd16);
        send_request(CMD_REAL, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 16'd1234, 5'd7);
        send_request(CMD_REAL, 8'h00, 8'h00, 8'h00, 8'h00, 16'd5, 5'd10);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                case ((n / PHASE_ITEMS) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                    default: begin send_idle_pct = 35; recv_stall_pct = 35; end
                endcase
            end
            send_random_request();
        end
        req_ch.valid <= 1'b0;

        // let the checker log the last request before reading its count
        @(negedge i_clk);
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> four_digit_seven_segment_formatter.f
src/fdssf_pkg.sv
src/fdssf_if.sv
src/fdssf_div_stage.sv
src/fdssf_lane.sv
src/four_digit_seven_segment_formatter.sv
verif/fdssf_display_check.sv
verif/tb.sv
